### rtl/creg_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the click rate edge gate.
package creg_pkg;

  localparam int PLAYERS_DEF   = 2;
  localparam int WINDOW_DEF    = 9;
  localparam int FRAC_BITS_DEF = 8;

  localparam int LOCK_W = 24;
  localparam int DT_W   = 20;
  localparam int FC_W   = 32;

  localparam logic [DT_W-1:0]   MEDIAN_RESET = 20'd4167;
  localparam logic [LOCK_W-1:0] LOCK_RESET   = 24'd30000;

  typedef enum logic [2:0] {
    OPC_TICK    = 3'd0,
    OPC_PRESS   = 3'd1,
    OPC_RELEASE = 3'd2,
    OPC_CLEAR   = 3'd3,
    OPC_REPORT  = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    RK_PASSED         = 3'd0,
    RK_BLOCKED        = 3'd1,
    RK_REPLAY_PRESS   = 3'd2,
    RK_REPLAY_RELEASE = 3'd3,
    RK_REPORT         = 3'd4
  } result_kind_t;

  typedef enum logic [1:0] {
    CFG_GATE_ENABLED  = 2'd0,
    CFG_DEBOUNCE_MODE = 2'd1,
    CFG_PRESS_LOCK    = 2'd2,
    CFG_RELEASE_LOCK  = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_EDGE,
    CMD_CLEAR,
    CMD_REPORT,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             press;
    logic             player;
    logic [1:0]       button;
    logic [DT_W-1:0]  dt;
  } cmd_t;

  typedef struct packed {
    result_kind_t kind;
    logic         player;
    logic [1:0]   button;
    logic         capped;
    logic         last;
  } result_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DECODE,
    B_MED,
    B_REPINIT,
    B_REP,
    B_RDIV,
    B_EDGE,
    B_EDIV,
    B_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    MED_IDLE,
    MED_CAND,
    MED_SCAN
  } med_state_t;

endpackage

### rtl/creg_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
interface creg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic        player_index;
  logic [1:0]  button_code;
  logic [19:0] frame_dt_us;
  modport source(output valid, opcode, player_index, button_code, frame_dt_us, input ready);
  modport sink(input valid, opcode, player_index, button_code, frame_dt_us, output ready);
endinterface

interface creg_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic       out_player;
  logic [1:0] out_button;
  logic       capped_seen;
  logic       last_of_run;
  modport source(output valid, result_kind, out_player, out_button, capped_seen, last_of_run,
                 input ready);
  modport sink(input valid, result_kind, out_player, out_button, capped_seen, last_of_run,
               output ready);
endinterface

### rtl/creg_ram.sv
`timescale 1ns / 1ps
// Generic RAM with one write port and two registered read ports.
module creg_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 9,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

### rtl/creg_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions, classifies them and queues commands.
module creg_front (
  input  logic           clk,
  input  logic           rst,
  creg_in_if.sink        in_ch,
  output logic           cmd_valid,
  output creg_pkg::cmd_t cmd,
  input  logic           cmd_pop
);
  creg_pkg::cmd_t cls;
  creg_pkg::cmd_t mem [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  logic           push;

  always_comb begin
    cls.press  = (in_ch.opcode == creg_pkg::OPC_PRESS);
    cls.player = in_ch.player_index;
    cls.button = in_ch.button_code;
    cls.dt     = in_ch.frame_dt_us;
    case (in_ch.opcode) inside
      creg_pkg::OPC_TICK:                       cls.kind = creg_pkg::CMD_TICK;
      creg_pkg::OPC_PRESS, creg_pkg::OPC_RELEASE: cls.kind = creg_pkg::CMD_EDGE;
      creg_pkg::OPC_CLEAR:                      cls.kind = creg_pkg::CMD_CLEAR;
      creg_pkg::OPC_REPORT:                     cls.kind = creg_pkg::CMD_REPORT;
      default:                                  cls.kind = creg_pkg::CMD_NONE;
    endcase
  end

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && (cls.kind != creg_pkg::CMD_NONE);
  assign cmd_valid   = (count != 2'd0);
  assign cmd         = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (cmd_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end
endmodule

### rtl/creg_med.sv
`timescale 1ns / 1ps
// Frame time window with a serial rank search for the median.
module creg_med #(
  parameter int WINDOW = creg_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [creg_pkg::DT_W-1:0]  dt,
  output logic                       done,
  output logic [creg_pkg::DT_W-1:0]  median
);
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  creg_pkg::med_state_t        state, state_next;
  logic [CW-1:0]               fill;
  logic [AW-1:0]               slot;
  logic [CW-1:0]               i;
  logic [CW-1:0]               j;
  logic [CW-1:0]               cnt;
  logic [CW-1:0]               cnt_n;
  logic                        hit;
  logic                        we;
  logic [AW-1:0]               raddr_b;
  logic [creg_pkg::DT_W-1:0]   rd_a;
  logic [creg_pkg::DT_W-1:0]   rd_b;

  assign we      = start && (state == creg_pkg::MED_IDLE);
  assign raddr_b = (j < fill) ? AW'(j) : '0;
  assign hit     = (j != '0) &&
                   ((rd_b < rd_a) || ((rd_b == rd_a) && ((j - CW'(1)) < i)));
  assign cnt_n   = cnt + CW'(hit);

  creg_ram #(.WIDTH(creg_pkg::DT_W), .DEPTH(WINDOW)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (slot),
    .wdata   (dt),
    .raddr_a (AW'(i)),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      creg_pkg::MED_IDLE: if (start) state_next = creg_pkg::MED_CAND;
      creg_pkg::MED_CAND: state_next = creg_pkg::MED_SCAN;
      creg_pkg::MED_SCAN: begin
        if (j == fill) begin
          state_next = (cnt_n == (fill >> 1)) ? creg_pkg::MED_IDLE : creg_pkg::MED_CAND;
        end
      end
      default: state_next = creg_pkg::MED_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= creg_pkg::MED_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      slot <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        creg_pkg::MED_IDLE: begin
          if (start) begin
            slot <= (slot == AW'(WINDOW - 1)) ? '0 : slot + AW'(1);
            if (fill != CW'(WINDOW)) begin
              fill <= fill + CW'(1);
            end
            i <= '0;
          end
        end
        creg_pkg::MED_CAND: begin
          j   <= '0;
          cnt <= '0;
        end
        creg_pkg::MED_SCAN: begin
          if (j == fill) begin
            if (cnt_n == (fill >> 1)) begin
              median <= rd_a;
              done   <= 1'b1;
            end else begin
              i <= i + CW'(1);
            end
          end else begin
            j   <= j + CW'(1);
            cnt <= cnt_n;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### rtl/creg_div.sv
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
module creg_div #(
  parameter int DW = 33,
  parameter int VW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CNTW = $clog2(DW + 1);

  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic [VW:0]     trial;
  logic            ge;

  assign trial = {rem, quotient[DW-1]};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        quotient <= dividend;
        dvs      <= divisor;
        rem      <= '0;
        cnt      <= CNTW'(DW);
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= ge ? VW'(trial - {1'b0, dvs}) : VW'(trial);
        quotient <= {quotient[DW-2:0], ge};
        cnt      <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/creg_back.sv
`timescale 1ns / 1ps
// Back end: gate state, frame count, lock arithmetic and result output.
module creg_back #(
  parameter int PLAYERS   = creg_pkg::PLAYERS_DEF,
  parameter int WINDOW    = creg_pkg::WINDOW_DEF,
  parameter int FRAC_BITS = creg_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [creg_pkg::LOCK_W-1:0] cfg_data,
  input  logic                        cmd_valid,
  input  creg_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  creg_out_if.source                  out_ch
);
  localparam int PIW  = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
  localparam int PTW  = creg_pkg::FC_W + FRAC_BITS;
  localparam int UW   = creg_pkg::LOCK_W + 1;
  localparam int DW   = UW + FRAC_BITS;
  localparam int NREP = (PLAYERS < 2) ? PLAYERS : 2;
  localparam logic [PTW-1:0] ONE_FRAME = PTW'(1) << FRAC_BITS;
  localparam logic [PTW-1:0] TENTH     = PTW'((2 ** FRAC_BITS) / 10);

  creg_pkg::back_state_t        state, state_next;
  creg_pkg::cmd_t               cmd_r;
  creg_pkg::result_t            res;
  creg_pkg::result_t            o_res;
  logic                         o_valid;

  logic                         gate_en;
  logic                         debounce;
  logic [creg_pkg::LOCK_W-1:0]  press_lock;
  logic [creg_pkg::LOCK_W-1:0]  release_lock;

  logic                         held   [PLAYERS];
  logic                         queued [PLAYERS];
  logic [1:0]                   pend   [PLAYERS];
  logic [PTW-1:0]               unlock [PLAYERS];
  logic [creg_pkg::FC_W-1:0]    fc;
  logic [creg_pkg::DT_W-1:0]    median_dt;
  logic                         capped;
  logic [1:0]                   pcnt;
  logic [1:0]                   mask;
  logic [1:0]                   mask_next;

  logic [PTW-1:0]               now_pt;
  logic [PIW-1:0]               tgt;
  logic                         unl;
  logic [PTW-1:0]               carried_pt;
  logic                         pvalid;
  logic                         eff;
  logic                         e_div;
  logic                         e_block;
  logic                         med_start;
  logic                         med_done;
  logic [creg_pkg::DT_W-1:0]    med_val;
  logic                         div_start;
  logic [UW-1:0]                div_us;
  logic                         div_busy;
  logic                         div_done;
  logic [DW-1:0]                div_q;
  logic [creg_pkg::DT_W-1:0]    divisor;

  function automatic logic is_unl(logic [PTW-1:0] now, logic [PTW-1:0] pt);
    return (now + TENTH) >= pt;
  endfunction

  function automatic logic [PTW-1:0] sat_add(logic [PTW-1:0] a, logic [DW-1:0] b);
    logic [PTW:0] s;
    s = {1'b0, a} + (PTW + 1)'(b);
    return s[PTW] ? '1 : s[PTW-1:0];
  endfunction

  assign now_pt     = {fc, {FRAC_BITS{1'b0}}};
  assign tgt        = (state == creg_pkg::B_REP || state == creg_pkg::B_RDIV) ?
                      PIW'(pcnt) : PIW'(cmd_r.player);
  assign unl        = is_unl(now_pt, unlock[tgt]);
  assign carried_pt = ({1'b0, now_pt} <= ({1'b0, unlock[tgt]} + {1'b0, ONE_FRAME})) ?
                      unlock[tgt] : now_pt;
  assign pvalid     = (PLAYERS > 1) || !cmd_r.player;
  assign eff        = queued[tgt] ? !held[tgt] : held[tgt];
  assign divisor    = (median_dt == '0) ? creg_pkg::DT_W'(1) : median_dt;

  always_comb begin
    e_div   = 1'b0;
    e_block = 1'b0;
    if (gate_en && pvalid) begin
      if (debounce) begin
        if (cmd_r.press) begin
          e_div   = unl;
          e_block = !unl;
        end
      end else if (!queued[tgt] && unl) begin
        e_div = 1'b1;
      end else begin
        e_block = 1'b1;
      end
    end
  end

  always_comb begin
    mask_next = 2'b00;
    for (int p = 0; p < NREP; p++) begin
      mask_next[p] = queued[p] && is_unl(now_pt, unlock[p]);
    end
  end

  creg_med #(.WINDOW(WINDOW)) u_med (
    .clk    (clk),
    .rst    (rst),
    .start  (med_start),
    .dt     (cmd_r.dt),
    .done   (med_done),
    .median (med_val)
  );

  creg_div #(.DW(DW), .VW(creg_pkg::DT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({div_us, {FRAC_BITS{1'b0}}}),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    med_start  = 1'b0;
    div_start  = 1'b0;
    div_us     = UW'(press_lock);
    unique case (state)
      creg_pkg::B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          state_next = creg_pkg::B_DECODE;
        end
      end
      creg_pkg::B_DECODE: begin
        unique case (cmd_r.kind)
          creg_pkg::CMD_TICK: begin
            if (cmd_r.dt != '0) begin
              med_start  = 1'b1;
              state_next = creg_pkg::B_MED;
            end else begin
              state_next = creg_pkg::B_REPINIT;
            end
          end
          creg_pkg::CMD_EDGE:   state_next = creg_pkg::B_EDGE;
          creg_pkg::CMD_REPORT: state_next = creg_pkg::B_EMIT;
          default:              state_next = creg_pkg::B_IDLE;
        endcase
      end
      creg_pkg::B_MED: if (med_done) state_next = creg_pkg::B_REPINIT;
      creg_pkg::B_REPINIT: state_next = gate_en ? creg_pkg::B_REP : creg_pkg::B_IDLE;
      creg_pkg::B_REP: begin
        if (pcnt == 2'(NREP)) begin
          state_next = creg_pkg::B_IDLE;
        end else if (mask[pcnt[0]]) begin
          div_start  = !div_busy;
          div_us     = held[tgt] ? UW'(release_lock) : UW'(press_lock);
          state_next = creg_pkg::B_RDIV;
        end
      end
      creg_pkg::B_RDIV: if (div_done) state_next = creg_pkg::B_EMIT;
      creg_pkg::B_EDGE: begin
        if (e_div) begin
          div_start  = !div_busy;
          if (debounce) begin
            div_us = UW'(press_lock) + UW'(release_lock);
          end else begin
            div_us = cmd_r.press ? UW'(press_lock) : UW'(release_lock);
          end
          state_next = creg_pkg::B_EDIV;
        end else begin
          state_next = creg_pkg::B_EMIT;
        end
      end
      creg_pkg::B_EDIV: if (div_done) state_next = creg_pkg::B_EMIT;
      creg_pkg::B_EMIT: begin
        if (!o_valid || out_ch.ready) begin
          state_next = (cmd_r.kind == creg_pkg::CMD_TICK) ? creg_pkg::B_REP : creg_pkg::B_IDLE;
        end
      end
      default: state_next = creg_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= creg_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_en      <= 1'b1;
      debounce     <= 1'b0;
      press_lock   <= creg_pkg::LOCK_RESET;
      release_lock <= creg_pkg::LOCK_RESET;
      fc           <= '0;
      median_dt    <= creg_pkg::MEDIAN_RESET;
      capped       <= 1'b0;
      o_valid      <= 1'b0;
      for (int p = 0; p < PLAYERS; p++) begin
        held[p]   <= 1'b0;
        queued[p] <= 1'b0;
        pend[p]   <= 2'd0;
        unlock[p] <= '0;
      end
    end else begin
      if (o_valid && out_ch.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        creg_pkg::B_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
          end
        end
        creg_pkg::B_DECODE: begin
          case (cmd_r.kind)
            creg_pkg::CMD_TICK: begin
              if (cmd_r.dt != '0) begin
                fc <= fc + creg_pkg::FC_W'(1);
              end
            end
            creg_pkg::CMD_CLEAR: begin
              capped <= 1'b0;
              for (int p = 0; p < PLAYERS; p++) begin
                held[p]   <= 1'b0;
                queued[p] <= 1'b0;
                pend[p]   <= 2'd0;
                unlock[p] <= '0;
              end
            end
            creg_pkg::CMD_REPORT: begin
              res    <= '{creg_pkg::RK_REPORT, 1'b0, 2'd0, capped, 1'b1};
              capped <= 1'b0;
            end
            default: ;
          endcase
        end
        creg_pkg::B_MED: begin
          if (med_done) begin
            median_dt <= med_val;
          end
        end
        creg_pkg::B_REPINIT: begin
          mask <= mask_next;
          pcnt <= 2'd0;
        end
        creg_pkg::B_REP: begin
          if (pcnt != 2'(NREP) && !mask[pcnt[0]]) begin
            pcnt <= pcnt + 2'd1;
          end
        end
        creg_pkg::B_RDIV: begin
          if (div_done) begin
            held[tgt]   <= !held[tgt];
            queued[tgt] <= 1'b0;
            unlock[tgt] <= sat_add(unlock[tgt], div_q);
            res <= '{(!held[tgt]) ? creg_pkg::RK_REPLAY_PRESS : creg_pkg::RK_REPLAY_RELEASE,
                     pcnt[0], pend[tgt], capped, pcnt[0] || !mask[1]};
            pcnt <= pcnt + 2'd1;
          end
        end
        creg_pkg::B_EDGE: begin
          if (e_block) begin
            capped <= 1'b1;
            res    <= '{creg_pkg::RK_BLOCKED, cmd_r.player, cmd_r.button, 1'b1, 1'b1};
            if (!debounce && (cmd_r.press != eff)) begin
              queued[tgt] <= !queued[tgt];
              if (!queued[tgt]) begin
                pend[tgt] <= cmd_r.button;
              end
            end
          end else if (!e_div) begin
            res <= '{creg_pkg::RK_PASSED, cmd_r.player, cmd_r.button, capped, 1'b1};
          end
        end
        creg_pkg::B_EDIV: begin
          if (div_done) begin
            unlock[tgt] <= sat_add(carried_pt, div_q);
            if (!debounce) begin
              held[tgt] <= cmd_r.press;
              pend[tgt] <= cmd_r.button;
            end
            res <= '{creg_pkg::RK_PASSED, cmd_r.player, cmd_r.button, capped, 1'b1};
          end
        end
        creg_pkg::B_EMIT: begin
          if (!o_valid || out_ch.ready) begin
            o_res   <= res;
            o_valid <= 1'b1;
          end
        end
        default: ;
      endcase
      if (cfg_we) begin
        unique case (creg_pkg::cfg_index_t'(cfg_index))
          creg_pkg::CFG_GATE_ENABLED:  gate_en      <= cfg_data[0];
          creg_pkg::CFG_DEBOUNCE_MODE: debounce     <= cfg_data[0];
          creg_pkg::CFG_PRESS_LOCK:    press_lock   <= cfg_data;
          creg_pkg::CFG_RELEASE_LOCK:  release_lock <= cfg_data;
          default: ;
        endcase
        for (int p = 0; p < PLAYERS; p++) begin
          held[p]   <= 1'b0;
          queued[p] <= 1'b0;
          pend[p]   <= 2'd0;
          unlock[p] <= '0;
        end
      end
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.result_kind = o_res.kind;
  assign out_ch.out_player  = o_res.player;
  assign out_ch.out_button  = o_res.button;
  assign out_ch.capped_seen = o_res.capped;
  assign out_ch.last_of_run = o_res.last;

  a_fc_step: assert property (@(posedge clk) disable iff (rst)
    (fc != $past(fc)) |-> (fc == $past(fc) + creg_pkg::FC_W'(1)) || $past(rst))
    else $error("Frame counter moved by other than one.");

  a_capped_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(capped) |-> $past(rst) ||
      $past(state == creg_pkg::B_DECODE &&
            (cmd_r.kind == creg_pkg::CMD_CLEAR || cmd_r.kind == creg_pkg::CMD_REPORT)))
    else $error("Capped flag cleared outside a clear or report.");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(o_valid) |-> $past(state == creg_pkg::B_EMIT))
    else $error("Result loaded outside the emit state.");
endmodule

### rtl/click_rate_edge_gate.sv
`timescale 1ns / 1ps
// Top level of the click rate edge gate: command queue front end and gate back end.
// An edge that locks the gate gives its result after a serial division in the divider;
// other edges skip the divider.
// A tick with a frame time adds the median rank search, and each replayed player adds a
// serial division; items run one at a time.
// A two-entry command queue and an output register let input and output stall independently.
// Synchronous reset restores register defaults, clears all gates, empties the frame window
// and sets the median frame time to 4167 us; the window memory needs no clearing pass.
module click_rate_edge_gate #(
  parameter int PLAYERS   = creg_pkg::PLAYERS_DEF,
  parameter int WINDOW    = creg_pkg::WINDOW_DEF,
  parameter int FRAC_BITS = creg_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [creg_pkg::LOCK_W-1:0] cfg_data,
  creg_in_if.sink                     in_ch,
  creg_out_if.source                  out_ch
);
  logic           cmd_valid;
  logic           cmd_pop;
  creg_pkg::cmd_t cmd;

  creg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  creg_back #(
    .PLAYERS   (PLAYERS),
    .WINDOW    (WINDOW),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );
endmodule

### verif/click_rate_edge_gate_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the gate's results from observed transactions and compares them.
module click_rate_edge_gate_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [creg_pkg::LOCK_W-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [2:0]                  in_opcode,
  input  logic                        in_player,
  input  logic [1:0]                  in_button,
  input  logic [19:0]                 in_dt,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [2:0]                  out_kind,
  input  logic                        out_player,
  input  logic [1:0]                  out_button,
  input  logic                        out_capped,
  input  logic                        out_last,
  output int                          fail_count,
  output int                          pending_results
);
  localparam int F = creg_pkg::FRAC_BITS_DEF;
  localparam logic [39:0] PT_MAX = {40{1'b1}};
  localparam logic [39:0] ONE_FRAME = 40'd1 << F;
  localparam logic [39:0] TENTH = ONE_FRAME / 10;

  logic                 gate_on, debounce;
  logic [23:0]          press_us, release_us;
  logic                 level [2];
  logic                 queued [2];
  logic [1:0]           queued_button [2];
  logic [39:0]          unlock_at [2];
  logic [31:0]          frames;
  logic [19:0]          dt_hist [9];
  int                   hist_fill, hist_slot;
  logic [19:0]          median;
  logic                 capped;
  creg_pkg::result_t    expected_results [$];

  assign pending_results = expected_results.size();

  function automatic logic [39:0] now_pt();
    return {frames, 8'd0};
  endfunction

  function automatic logic [39:0] frames_for(logic [24:0] us);
    logic [63:0] d;
    d = (median == 0) ? 64'd1 : 64'(median);
    return 40'((64'(us) << F) / d);
  endfunction

  function automatic logic [39:0] sat_sum(logic [39:0] a, logic [39:0] b);
    logic [40:0] s;
    s = 41'(a) + 41'(b);
    return s > 41'(PT_MAX) ? PT_MAX : s[39:0];
  endfunction

  function automatic logic free_at(logic [39:0] pt);
    return 41'(now_pt()) + 41'(TENTH) >= 41'(pt);
  endfunction

  function automatic logic [39:0] carry_pt(logic [39:0] pt);
    return (41'(now_pt()) <= 41'(pt) + 41'(ONE_FRAME)) ? pt : now_pt();
  endfunction

  task automatic clear_gates();
    for (int p = 0; p < 2; p++) begin
      level[p] = 0;
      queued[p] = 0;
      queued_button[p] = 0;
      unlock_at[p] = 0;
    end
  endtask

  task automatic track_frame(logic [19:0] dt);
    logic [19:0] s [9];
    logic [19:0] v;
    int j;
    dt_hist[hist_slot] = dt;
    hist_slot = (hist_slot + 1) % 9;
    if (hist_fill < 9) hist_fill++;
    for (int i = 0; i < 9; i++) s[i] = dt_hist[i];
    for (int i = 1; i < hist_fill; i++) begin
      v = s[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    median = s[hist_fill / 2];
  endtask

  task automatic push(creg_pkg::result_kind_t k, logic p, logic [1:0] b, logic last);
    creg_pkg::result_t r;
    r.kind = k;
    r.player = p;
    r.button = b;
    r.capped = capped;
    r.last = last;
    expected_results.push_back(r);
  endtask

  function automatic logic gate_edge(logic p, logic [1:0] b, logic press);
    logic eff;
    if (!gate_on) return 1;
    if (debounce) begin
      if (!press) return 1;
      if (free_at(unlock_at[p])) begin
        unlock_at[p] = sat_sum(carry_pt(unlock_at[p]),
                               frames_for(25'(press_us) + 25'(release_us)));
        return 1;
      end
      capped = 1;
      return 0;
    end
    if (!queued[p] && free_at(unlock_at[p])) begin
      level[p] = press;
      queued_button[p] = b;
      unlock_at[p] = sat_sum(carry_pt(unlock_at[p]),
                             frames_for(press ? 25'(press_us) : 25'(release_us)));
      return 1;
    end
    eff = queued[p] ? !level[p] : level[p];
    capped = 1;
    if (press == eff) return 0;
    if (!queued[p]) begin
      queued[p] = 1;
      queued_button[p] = b;
    end else begin
      queued[p] = 0;
    end
    return 0;
  endfunction

  task automatic predict(logic [2:0] op, logic p, logic [1:0] b, logic [19:0] dt);
    int n;
    logic ok;
    creg_pkg::result_t r;
    n = 0;
    case (op)
      creg_pkg::OPC_TICK: begin
        if (dt != 0) begin
          frames++;
          track_frame(dt);
        end
        if (gate_on) begin
          for (int q = 0; q < 2; q++) begin
            if (queued[q] && free_at(unlock_at[q])) begin
              level[q] = !level[q];
              queued[q] = 0;
              unlock_at[q] = sat_sum(unlock_at[q],
                                     frames_for(level[q] ? 25'(press_us) : 25'(release_us)));
              push(level[q] ? creg_pkg::RK_REPLAY_PRESS : creg_pkg::RK_REPLAY_RELEASE,
                   q[0], queued_button[q], 0);
              n++;
            end
          end
          if (n > 0) begin
            r = expected_results.pop_back();
            r.last = 1;
            expected_results.push_back(r);
          end
        end
      end
      creg_pkg::OPC_PRESS, creg_pkg::OPC_RELEASE: begin
        ok = gate_edge(p, b, op == creg_pkg::OPC_PRESS);
        push(ok ? creg_pkg::RK_PASSED : creg_pkg::RK_BLOCKED, p, b, 1);
      end
      creg_pkg::OPC_CLEAR: begin
        clear_gates();
        capped = 0;
      end
      creg_pkg::OPC_REPORT: begin
        push(creg_pkg::RK_REPORT, 0, 0, 1);
        capped = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    creg_pkg::result_t e;
    if (rst) begin
      gate_on = 1;
      debounce = 0;
      press_us = creg_pkg::LOCK_RESET;
      release_us = creg_pkg::LOCK_RESET;
      clear_gates();
      frames = 0;
      hist_fill = 0;
      hist_slot = 0;
      median = creg_pkg::MEDIAN_RESET;
      capped = 0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d player=%0d button=%0d", $time,
                   out_kind, out_player, out_button);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (out_kind !== e.kind || out_player !== e.player || out_button !== e.button ||
              out_capped !== e.capped || out_last !== e.last) begin
            $display("%0t: mismatch expected %0d/%0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d/%0d",
                     $time, e.kind, e.player, e.button, e.capped, e.last,
                     out_kind, out_player, out_button, out_capped, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) predict(in_opcode, in_player, in_button, in_dt);
      if (cfg_we) begin
        case (cfg_index)
          creg_pkg::CFG_GATE_ENABLED:  gate_on = cfg_data[0];
          creg_pkg::CFG_DEBOUNCE_MODE: debounce = cfg_data[0];
          creg_pkg::CFG_PRESS_LOCK:    press_us = cfg_data;
          creg_pkg::CFG_RELEASE_LOCK:  release_us = cfg_data;
          default: ;
        endcase
        clear_gates();
      end
    end
  end
endmodule

### verif/tb_click_rate_edge_gate.sv
`timescale 1ns / 1ps
// Testbench top: drives stimulus and configuration into the edge gate and reports the verdict.
module tb_click_rate_edge_gate;
  localparam int WATCHDOG = 200000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = creg_pkg::CFG_GATE_ENABLED;
  logic [23:0] cfg_data = 0;
  int          fail_count, pending_results;
  int          idle_cycles;
  logic        long_hold = 0;

  creg_in_if  in_ch ();
  creg_out_if out_ch ();

  initial begin
    in_ch.valid = 0;
    in_ch.opcode = creg_pkg::OPC_TICK;
    in_ch.player_index = 0;
    in_ch.button_code = 0;
    in_ch.frame_dt_us = 0;
    out_ch.ready = 0;
  end

  always #2 clk = ~clk;

  click_rate_edge_gate dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  click_rate_edge_gate_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_opcode(in_ch.opcode),
    .in_player(in_ch.player_index), .in_button(in_ch.button_code),
    .in_dt(in_ch.frame_dt_us),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.result_kind),
    .out_player(out_ch.out_player), .out_button(out_ch.out_button),
    .out_capped(out_ch.capped_seen), .out_last(out_ch.last_of_run),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    while (1) begin
      if (long_hold) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send(logic [2:0] op, logic p, logic [1:0] b, logic [19:0] dt, int gap);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.player_index <= p;
    in_ch.button_code <= b;
    in_ch.frame_dt_us <= dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(int count, int max_dt);
    int r, gap;
    logic [2:0] op;
    logic [19:0] dt;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = creg_pkg::OPC_TICK;
      else if (r < 65) op = creg_pkg::OPC_PRESS;
      else if (r < 90) op = creg_pkg::OPC_RELEASE;
      else if (r < 93) op = creg_pkg::OPC_CLEAR;
      else if (r < 97) op = creg_pkg::OPC_REPORT;
      else op = 3'($urandom_range(5, 7));
      r = $urandom_range(0, 19);
      if (r == 0) dt = 0;
      else if (r == 1) dt = 20'($urandom_range(0, 20'hFFFFF));
      else dt = 20'($urandom_range(1, max_dt));
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      send(op, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), dt, gap);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(creg_pkg::OPC_PRESS, 1'b0, 2'd0, 20'd0, 0);
    send(creg_pkg::OPC_PRESS, 1'b0, 2'd1, 20'd0, 0);
    send(creg_pkg::OPC_RELEASE, 1'b0, 2'd2, 20'd0, 0);
    send(creg_pkg::OPC_RELEASE, 1'b0, 2'd2, 20'd0, 0);
    send(creg_pkg::OPC_PRESS, 1'b1, 2'd3, 20'hFFFFF, 0);
    send(creg_pkg::OPC_TICK, 1'b0, 2'd0, 20'd0, 0);
    for (int i = 0; i < 10; i++) send(creg_pkg::OPC_TICK, 1'b0, 2'd0, 20'd4167, 1);
    send(creg_pkg::OPC_TICK, 1'b1, 2'd3, 20'hFFFFF, 0);
    send(creg_pkg::OPC_REPORT, 1'b0, 2'd0, 20'd0, 0);
    send(creg_pkg::OPC_REPORT, 1'b0, 2'd0, 20'd0, 0);
    send(creg_pkg::OPC_RELEASE, 1'b1, 2'd1, 20'd0, 0);
    send(creg_pkg::OPC_CLEAR, 1'b0, 2'd0, 20'd0, 0);
    send(3'd7, 1'b1, 2'd2, 20'd0, 0);
    send(3'd5, 1'b0, 2'd1, 20'd0, 0);
    drain();

    write_reg(creg_pkg::CFG_PRESS_LOCK, 24'd0);
    write_reg(creg_pkg::CFG_RELEASE_LOCK, 24'd0);
    random_phase(120, 20000);
    drain();

    write_reg(creg_pkg::CFG_PRESS_LOCK, 24'd10000000);
    write_reg(creg_pkg::CFG_RELEASE_LOCK, 24'd10000000);
    random_phase(120, 1000000);
    drain();

    write_reg(creg_pkg::CFG_GATE_ENABLED, 24'hFFFFFE);
    random_phase(120, 20000);
    drain();

    write_reg(creg_pkg::CFG_GATE_ENABLED, 24'd1);
    write_reg(creg_pkg::CFG_DEBOUNCE_MODE, 24'd1);
    write_reg(creg_pkg::CFG_PRESS_LOCK, 24'd8000);
    write_reg(creg_pkg::CFG_RELEASE_LOCK, 24'd5000);
    random_phase(200, 10000);
    drain();

    write_reg(creg_pkg::CFG_DEBOUNCE_MODE, 24'd0);
    write_reg(creg_pkg::CFG_PRESS_LOCK, 24'd12000);
    write_reg(creg_pkg::CFG_RELEASE_LOCK, 24'd9000);
    long_hold = 1;
    random_phase(300, 8000);
    drain();

    write_reg(creg_pkg::CFG_PRESS_LOCK, 24'($urandom_range(0, 60000)));
    write_reg(creg_pkg::CFG_RELEASE_LOCK, 24'($urandom_range(0, 60000)));
    random_phase(300, 8000);
    drain();

    write_reg(creg_pkg::CFG_PRESS_LOCK, creg_pkg::LOCK_RESET);
    write_reg(creg_pkg::CFG_RELEASE_LOCK, creg_pkg::LOCK_RESET);
    random_phase(270, 5000);
    drain();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### click_rate_edge_gate.f
rtl/creg_pkg.sv
rtl/creg_if.sv
rtl/creg_ram.sv
rtl/creg_front.sv
rtl/creg_med.sv
rtl/creg_div.sv
rtl/creg_back.sv
rtl/click_rate_edge_gate.sv
verif/click_rate_edge_gate_checker.sv
verif/tb_click_rate_edge_gate.sv
